[rtl/lzw_pkg.sv]
// ----------------------------------------------------------------------------
// lzw_pkg
// Shared constants and controller/datapath command and status types for the
// LZW byte compressor.
// ----------------------------------------------------------------------------
`default_nettype none

package lzw_pkg;

  localparam int CODE_BITS  = 12;
  localparam int CODE_COUNT = 1 << CODE_BITS;
  localparam int BYTE_W     = 8;
  localparam int OUT_W      = 12;
  localparam int FIRST_FREE = 256;

  typedef logic [CODE_BITS-1:0] code_t;
  typedef logic [CODE_BITS:0]   free_t;

  // Codes below 256 are never children, so code zero marks an empty link.
  localparam code_t NO_LINK = '0;

  typedef struct packed {
    logic load_item;
    logic start_prefix;
    logic walk_head;
    logic walk_next;
    logic hit;
    logic emit_prefix;
    logic new_prefix;
    logic add_node;
    logic add_link;
    logic emit_last;
  } cmd_t;

  typedef struct packed {
    logic prefix_valid;
    logic last;
    logic head_none;
    logic node_match;
    logic sib_none;
    logic dict_full;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

[rtl/lzw_byte_if.sv]
// ----------------------------------------------------------------------------
// lzw_byte_if
// Byte input channel: valid/ready handshake carrying one byte and its
// end-of-stream flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface lzw_byte_if;
  import lzw_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              final_byte;

  modport source (output valid, output in_byte, output final_byte, input ready);
  modport sink   (input valid, input in_byte, input final_byte, output ready);
endinterface

`default_nettype wire

[rtl/lzw_code_if.sv]
// ----------------------------------------------------------------------------
// lzw_code_if
// Code output channel: valid/ready handshake carrying one code and its
// end-of-stream flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface lzw_code_if;
  import lzw_pkg::*;

  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] out_code;
  logic             stream_end;

  modport source (output valid, output out_code, output stream_end, input ready);
  modport sink   (input valid, input out_code, input stream_end, output ready);
endinterface

`default_nettype wire

[rtl/lzw_byte_compressor.sv]
// ----------------------------------------------------------------------------
// lzw_byte_compressor
// LZW compressor: bytes in, codes out, with the dictionary kept as a trie.
// ----------------------------------------------------------------------------
// Usage:
//   byte_in carries one byte per beat; final_byte marks the last byte of a
//   stream. code_out carries one code per beat; stream_end marks the last
//   code of a stream, after which the dictionary starts afresh.
//   The first byte of a stream only starts the prefix. Any later byte reads
//   the first child of the prefix, then compares it and every further
//   sibling in turn (at most 256 siblings) until one matches or none is left.
//   A byte that ends a match emits the code and then links the new entry
//   into the child and node RAMs; once every code is in use it only emits
//   the code. The last byte also emits the final code. The sibling walk in
//   the node RAM, one read per cycle, sets the rate. Codes leave through an
//   output register, so a code reaches code_out in the cycle after it is
//   decided. The block keeps taking bytes while a code waits there; it waits
//   only when it must emit another code and the receiver has not yet taken
//   the one held.
//   Reset clears the prefix valid flag, the code counter and the root link
//   flags; the RAM contents need no clearing, and bytes are accepted in the
//   first cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module lzw_byte_compressor (
  input  logic       clk,
  input  logic       rst,
  lzw_byte_if.sink   byte_in,
  lzw_code_if.source code_out
);
  import lzw_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lzw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (byte_in.valid),
    .in_last  (byte_in.final_byte),
    .in_ready (byte_in.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lzw_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_byte   (byte_in.in_byte),
    .in_last   (byte_in.final_byte),
    .out_valid (code_out.valid),
    .out_ready (code_out.ready),
    .out_code  (code_out.out_code),
    .out_end   (code_out.stream_end)
  );

  a_link_follows_add: assert property (@(posedge clk) disable iff (rst)
    cmd.add_node |=> cmd.add_link)
    else $error("dictionary insert did not complete its link write");

  a_no_add_when_full: assert property (@(posedge clk) disable iff (rst)
    cmd.add_node |-> !sts.dict_full)
    else $error("entry added with all codes in use");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_prefix || cmd.emit_last) |-> sts.out_free)
    else $error("code emitted over a pending result");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (cmd.walk_head || cmd.walk_next || cmd.add_node || cmd.add_link) |-> !byte_in.ready)
    else $error("byte input ready while a byte is in progress");

endmodule

`default_nettype wire

[rtl/lzw_ram.sv]
// ----------------------------------------------------------------------------
// lzw_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lzw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

[rtl/lzw_dp.sv]
// ----------------------------------------------------------------------------
// lzw_dp
// Datapath: prefix and code registers, the dictionary as a trie of
// first-child and sibling links in two RAMs, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lzw_dp (
  input  logic                      clk,
  input  logic                      rst,
  input  lzw_pkg::cmd_t             cmd,
  output lzw_pkg::sts_t             sts,
  input  logic [lzw_pkg::BYTE_W-1:0] in_byte,
  input  logic                      in_last,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [lzw_pkg::OUT_W-1:0] out_code,
  output logic                      out_end
);
  import lzw_pkg::*;

  localparam int NODE_W = BYTE_W + CODE_BITS;
  localparam int ROOTS  = 1 << BYTE_W;

  code_t              prefix;
  logic               prefix_valid;
  free_t              next_free;
  logic [BYTE_W-1:0]  byte_r;
  logic               last_r;
  code_t              cur;
  code_t              head;
  logic [ROOTS-1:0]   root_valid;

  logic               prefix_root;
  code_t              head_val;
  code_t              free_code;

  logic               child_we;
  code_t              child_addr;
  code_t              child_wdata;
  code_t              child_rdata;

  logic               node_we;
  code_t              node_addr;
  logic [NODE_W-1:0]  node_wdata;
  logic [NODE_W-1:0]  node_rdata;
  logic [BYTE_W-1:0]  node_byte;
  code_t              node_sib;

  assign free_code   = next_free[CODE_BITS-1:0];
  assign prefix_root = (prefix[CODE_BITS-1:BYTE_W] == '0);

  // A single-byte code has a first child only once one was linked in this stream.
  assign head_val = (prefix_root && !root_valid[prefix[BYTE_W-1:0]]) ? NO_LINK : child_rdata;

  assign node_byte = node_rdata[NODE_W-1:CODE_BITS];
  assign node_sib  = node_rdata[CODE_BITS-1:0];

  // First-child table: read at the prefix while idle, written when a code is added.
  assign child_we    = cmd.add_node | cmd.add_link;
  assign child_addr  = cmd.add_node ? free_code : prefix;
  assign child_wdata = cmd.add_node ? NO_LINK : free_code;

  lzw_ram #(.WIDTH(CODE_BITS), .DEPTH(CODE_COUNT)) u_child_ram (
    .clk   (clk),
    .we    (child_we),
    .addr  (child_addr),
    .wdata (child_wdata),
    .rdata (child_rdata)
  );

  // Node table: byte and next sibling of every added code.
  assign node_we    = cmd.add_node;
  assign node_wdata = {byte_r, head};

  always_comb begin
    priority if (cmd.add_node) begin
      node_addr = free_code;
    end else if (cmd.walk_head) begin
      node_addr = head_val;
    end else begin
      node_addr = node_sib;
    end
  end

  lzw_ram #(.WIDTH(NODE_W), .DEPTH(CODE_COUNT)) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .addr  (node_addr),
    .wdata (node_wdata),
    .rdata (node_rdata)
  );

  assign sts.prefix_valid = prefix_valid;
  assign sts.last         = last_r;
  assign sts.head_none    = (head_val == NO_LINK);
  assign sts.node_match   = (node_byte == byte_r);
  assign sts.sib_none     = (node_sib == NO_LINK);
  assign sts.dict_full    = next_free[CODE_BITS];
  assign sts.out_free     = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      byte_r <= in_byte;
      last_r <= in_last;
    end
    if (cmd.walk_head) begin
      cur  <= head_val;
      head <= head_val;
    end else if (cmd.walk_next) begin
      cur <= node_sib;
    end
    priority if (cmd.start_prefix) begin
      prefix <= CODE_BITS'(in_byte);
    end else if (cmd.hit) begin
      prefix <= cur;
    end else if (cmd.new_prefix || cmd.add_link) begin
      prefix <= CODE_BITS'(byte_r);
    end else if (cmd.emit_last) begin
      prefix <= '0;
    end
    if (cmd.emit_prefix || cmd.emit_last) begin
      out_code <= OUT_W'(prefix);
      out_end  <= cmd.emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_valid <= 1'b0;
      next_free    <= free_t'(FIRST_FREE);
      root_valid   <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.start_prefix) begin
        prefix_valid <= 1'b1;
      end
      if (cmd.emit_last) begin
        prefix_valid <= 1'b0;
        next_free    <= free_t'(FIRST_FREE);
        root_valid   <= '0;
      end else if (cmd.add_link) begin
        next_free <= next_free + free_t'(1);
        if (prefix_root) begin
          root_valid[prefix[BYTE_W-1:0]] <= 1'b1;
        end
      end
      if (cmd.emit_prefix || cmd.emit_last) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/lzw_ctrl.sv]
// ----------------------------------------------------------------------------
// lzw_ctrl
// Controller: sequences the child lookup, the sibling walk, the code emits
// and the add and link steps of the dictionary insertion for each byte.
// ----------------------------------------------------------------------------
`default_nettype none

module lzw_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_last,
  output logic          in_ready,
  input  lzw_pkg::sts_t sts,
  output lzw_pkg::cmd_t cmd
);
  import lzw_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD,
    S_WALK,
    S_MISS,
    S_ADD,
    S_LINK,
    S_END
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE) && !rst;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load_item = 1'b1;
          if (!sts.prefix_valid) begin
            cmd.start_prefix = 1'b1;
            state_next = in_last ? S_END : S_IDLE;
          end else begin
            state_next = S_HEAD;
          end
        end
      end
      S_HEAD: begin
        cmd.walk_head = 1'b1;
        state_next = sts.head_none ? S_MISS : S_WALK;
      end
      S_WALK: begin
        if (sts.node_match) begin
          cmd.hit = 1'b1;
          state_next = sts.last ? S_END : S_IDLE;
        end else begin
          cmd.walk_next = 1'b1;
          if (sts.sib_none) begin
            state_next = S_MISS;
          end
        end
      end
      S_MISS: begin
        if (sts.out_free) begin
          cmd.emit_prefix = 1'b1;
          if (sts.dict_full) begin
            cmd.new_prefix = 1'b1;
            state_next = sts.last ? S_END : S_IDLE;
          end else begin
            state_next = S_ADD;
          end
        end
      end
      S_ADD: begin
        cmd.add_node = 1'b1;
        state_next = S_LINK;
      end
      S_LINK: begin
        cmd.add_link = 1'b1;
        state_next = sts.last ? S_END : S_IDLE;
      end
      S_END: begin
        if (sts.out_free) begin
          cmd.emit_last = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

[verif/lzw_byte_compressor_tb.sv]
// ----------------------------------------------------------------------------
// lzw_byte_compressor_tb
// Drives byte streams into the LZW compressor and checks every code that it
// emits. Expected codes come from a behavioral LZW dictionary kept in the
// bench. The run covers short hand-picked streams, random streams under
// several idling mixes and a long output hold-off.
// ----------------------------------------------------------------------------
module lzw_byte_compressor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lzw_pkg::*;

  typedef struct {
    logic [OUT_W-1:0] out_code;
    logic             stream_end;
  } code_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lzw_byte_if byte_ch ();
  lzw_code_if code_ch ();

  lzw_byte_compressor u_top (
    .clk      (clk),
    .rst      (rst),
    .byte_in  (byte_ch),
    .code_out (code_ch)
  );

  always #6 clk = ~clk;

  // Behavioral dictionary: key is {prefix code, byte}, value is its code.
  code_t      trie_map [int unsigned];
  code_t      pfx_code  = '0;
  logic       pfx_live  = 1'b0;
  free_t      next_code = free_t'(FIRST_FREE);
  code_beat_t pending_codes [$];

  int src_idle_pct = 0;
  int stall_pct    = 0;
  int hold_len     = 0;
  int hold_cnt     = 0;

  int errors       = 0;
  int bytes_sent   = 0;
  int codes_seen   = 0;
  int streams_done = 0;

  initial begin
    byte_ch.valid      = 1'b0;
    byte_ch.in_byte    = '0;
    byte_ch.final_byte = 1'b0;
    code_ch.ready      = 1'b0;
  end

  // Works out the codes that one accepted byte produces.
  function automatic void predict_codes(input logic [BYTE_W-1:0] b, input logic fin);
    int unsigned key;
    if (!pfx_live) begin
      pfx_code = code_t'(b);
      pfx_live = 1'b1;
    end else begin
      key = 32'({pfx_code, b});
      if (trie_map.exists(key)) begin
        pfx_code = trie_map[key];
      end else begin
        pending_codes.push_back('{out_code: OUT_W'(pfx_code), stream_end: 1'b0});
        if (next_code < CODE_COUNT) begin
          trie_map[key] = code_t'(next_code);
          next_code++;
        end
        pfx_code = code_t'(b);
      end
    end
    if (fin) begin
      pending_codes.push_back('{out_code: OUT_W'(pfx_code), stream_end: 1'b1});
      pfx_code  = '0;
      pfx_live  = 1'b0;
      next_code = free_t'(FIRST_FREE);
      trie_map.delete();
      streams_done++;
    end
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fin);
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      byte_ch.valid      <= 1'b0;
      byte_ch.in_byte    <= BYTE_W'($urandom);
      byte_ch.final_byte <= 1'($urandom_range(1));
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    byte_ch.valid      <= 1'b1;
    byte_ch.in_byte    <= b;
    byte_ch.final_byte <= fin;
    do @(posedge clk); while (!byte_ch.ready);
    predict_codes(b, fin);
    bytes_sent++;
  endtask

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin : receiver
    if (hold_len != 0) begin
      hold_cnt = hold_len;
      hold_len = 0;
    end
    if (hold_cnt != 0) begin
      hold_cnt--;
      code_ch.ready <= 1'b0;
    end else begin
      code_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : check_codes
    code_beat_t exp_beat;
    if (!rst && code_ch.valid && code_ch.ready) begin
      codes_seen++;
      if (pending_codes.size() == 0) begin
        $error("out_code: no code expected, got %0d (stream_end %0b)",
               code_ch.out_code, code_ch.stream_end);
        errors++;
      end else begin
        exp_beat = pending_codes.pop_front();
        if (code_ch.out_code !== exp_beat.out_code) begin
          $error("out_code: expected %0d, got %0d", exp_beat.out_code, code_ch.out_code);
          errors++;
        end
        if (code_ch.stream_end !== exp_beat.stream_end) begin
          $error("stream_end: expected %0b, got %0b", exp_beat.stream_end,
                 code_ch.stream_end);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    int i;
    src_idle_pct = 0;
    stall_pct    = 0;
    // Single-byte streams: only the final code comes out.
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    // The final byte misses, so it causes two codes.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    // A run of one value builds ever longer matches; the final byte hits.
    for (i = 0; i < 6; i++) send_byte(8'h07, i == 5);
    for (i = 0; i < 6; i++) send_byte(i[0] ? 8'h55 : 8'hAA, i == 5);
    for (i = 0; i < 6; i++) send_byte(i[1] ? 8'hFF : 8'h00, i == 5);
  endtask

  // Random streams; small alphabets make long matches likely.
  task automatic random_streams(input int n_items);
    int sent, len, i, mode;
    logic [BYTE_W-1:0] base, b;
    sent = 0;
    while (sent < n_items) begin
      len  = ($urandom_range(9) == 0) ? 1 : $urandom_range(40, 2);
      mode = $urandom_range(3);
      base = BYTE_W'($urandom);
      for (i = 0; i < len; i++) begin
        case (mode)
          0: b = BYTE_W'($urandom);
          1: b = $urandom_range(1) ? base : ~base;
          2: b = base + BYTE_W'($urandom_range(3));
          default: b = ($urandom_range(7) == 0) ? BYTE_W'($urandom) : base;
        endcase
        send_byte(b, i == len - 1);
        sent++;
      end
    end
  endtask

  task automatic test_idle_mixes();
    src_idle_pct = 0;  stall_pct = 0;  random_streams(160);
    src_idle_pct = 57; stall_pct = 0;  random_streams(160);
    src_idle_pct = 0;  stall_pct = 57; random_streams(160);
    src_idle_pct = 24; stall_pct = 24; random_streams(160);
  endtask

  // The receiver holds off while bytes keep coming, so the input must stall.
  task automatic test_backpressure();
    int i;
    src_idle_pct = 0;
    stall_pct    = 0;
    hold_len     = 400;
    for (i = 0; i < 30; i++) send_byte(BYTE_W'($urandom), i == 29);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_idle_mixes();
    test_backpressure();
    byte_ch.valid <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (pending_codes.size() != 0) begin
      $error("out_code: %0d expected codes never arrived", pending_codes.size());
      errors++;
    end
    $display("Sent %0d bytes in %0d streams and checked %0d codes,", bytes_sent,
             streams_done, codes_seen);
    $display("over directed patterns, four idling mixes and a long receiver hold-off.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("Verification failed");
    $finish;
  end

endmodule

[filelist.f]
rtl/lzw_pkg.sv
rtl/lzw_byte_if.sv
rtl/lzw_code_if.sv
rtl/lzw_ram.sv
rtl/lzw_dp.sv
rtl/lzw_ctrl.sv
rtl/lzw_byte_compressor.sv
verif/lzw_byte_compressor_tb.sv
